// File: hw/rtl/ra_pkg.sv
// ra_pkg: shared types and constants for the rational accumulator
// no dependencies

package ra_pkg;

   localparam int WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_ABS  = 2'd2,
      ACT_RSVD = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_RSVD     = 2'd3
   } status_type;

   // request to the shared divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

endpackage

// File: hw/rtl/ra_if.sv
// ra_if: valid/ready channel interfaces for request and response
// no dependencies

interface ra_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic signed [31:0] operand_numerator;
   logic signed [31:0] operand_denominator;
   modport source (output valid, action, operand_numerator, operand_denominator, input ready);
   modport sink (input valid, action, operand_numerator, operand_denominator, output ready);
endinterface

interface ra_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_numerator;
   logic [30:0] result_denominator;
   logic [1:0]  status;
   modport source (output valid, result_numerator, result_denominator, status, input ready);
   modport sink (input valid, result_numerator, result_denominator, status, output ready);
endinterface

// File: hw/rtl/rational_accumulator.sv
// rational_accumulator: held fraction with load, add and abs, gcd reduced
// depends on ra_pkg, ra_if, ra_divider
//
// load/add pass S_MUL, then run the euclid steps and the two
// reductions by the gcd on the divider; abs and rejected items skip it
// one transaction at a time: the 64-bit shift-subtract divider sets the rate
// synchronous reset brings the fraction to 0/1 and the channels to idle

module rational_accumulator
   import ra_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEF
)(
   input logic clock,
   input logic reset,
   ra_req_if.sink   req,
   ra_rsp_if.source rsp
);

   localparam logic [63:0] LIMIT = (64'd1 << (WIDTH - 1)) - 64'd1;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] num_ff;
   logic [31:0] den_ff;
   logic [1:0]  status_ff;
   logic        neg_ff;
   logic [63:0] nmag_ff, dmag_ff;   // unreduced magnitude and denominator
   logic [63:0] ga_ff, gb_ff;       // euclid operands
   logic [63:0] qn_ff;              // reduced numerator magnitude
   logic        wait_ff;            // divider launched, awaiting done
   logic [1:0]  act_ff;
   logic [31:0] tn_ff, td_ff;
   logic        rsp_valid_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   ra_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // operand magnitudes
   logic [31:0] t_mag, d_mag, a_mag;
   logic        tneg, dneg, aneg;
   logic [63:0] p1, p2, sum;
   logic        sneg;
   logic [63:0] g;

   assign tneg  = tn_ff[31];
   assign dneg  = td_ff[31];
   assign aneg  = num_ff[31];
   assign t_mag = tneg ? (32'd0 - tn_ff) : tn_ff;
   assign d_mag = dneg ? (32'd0 - td_ff) : td_ff;
   assign a_mag = aneg ? (32'd0 - num_ff) : num_ff;
   assign g     = (ga_ff == 64'd0) ? 64'd1 : ga_ff;

   // cross products, one multiplier each, registered in S_MUL
   always_comb begin
      p1 = {32'd0, a_mag} * {32'd0, d_mag};
      p2 = {32'd0, t_mag} * {32'd0, den_ff};
      if (aneg == tneg) begin
         sum = p1 + p2; sneg = aneg;
      end else if (p1 >= p2) begin
         sum = p1 - p2; sneg = aneg;
      end else begin
         sum = p2 - p1; sneg = tneg;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = ga_ff;
      dreq.divisor  = gb_ff;
      case (state_ff)
         S_GCD: begin
            dreq.start = !wait_ff && gb_ff != 64'd0;
         end
         S_DIVN: begin
            dreq.start = !wait_ff; dreq.dividend = nmag_ff; dreq.divisor = g;
         end
         S_DIVD: begin
            dreq.start = !wait_ff; dreq.dividend = dmag_ff; dreq.divisor = g;
         end
         default: dreq.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_ff       <= '0;
         den_ff       <= 32'd1;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  act_ff <= req.action;
                  tn_ff  <= req.operand_numerator;
                  td_ff  <= req.operand_denominator;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // zero denominator on load or add is rejected up front
               status_ff <= (act_ff inside {ACT_LOAD, ACT_ADD} && td_ff == 32'd0)
                            ? ST_ZERO_DEN : ST_OK;
               wait_ff   <= 1'b0;
               if (act_ff inside {ACT_LOAD, ACT_ADD}) begin
                  if (td_ff == 32'd0) begin
                     state_ff  <= S_OUT;
                  end else if (act_ff == ACT_LOAD) begin
                     neg_ff  <= tneg != dneg;
                     nmag_ff <= {32'd0, t_mag};
                     dmag_ff <= {32'd0, d_mag};
                     ga_ff   <= {32'd0, t_mag};
                     gb_ff   <= {32'd0, d_mag};
                     state_ff <= S_GCD;
                  end else begin
                     // denominator product fits one 32x32 multiply
                     neg_ff  <= sneg ^ dneg;
                     nmag_ff <= sum;
                     dmag_ff <= {32'd0, den_ff} * {32'd0, d_mag};
                     ga_ff   <= sum;
                     gb_ff   <= {32'd0, den_ff} * {32'd0, d_mag};
                     state_ff <= S_GCD;
                  end
               end else begin
                  if (act_ff == ACT_ABS) num_ff <= a_mag;
                  state_ff <= S_OUT;
               end
            end
            S_GCD: begin
               // euclid: (a, b) <- (b, a mod b) via the divider
               if (gb_ff == 64'd0) begin
                  state_ff <= S_DIVN;
                  wait_ff  <= 1'b0;
               end else if (!wait_ff) begin
                  wait_ff <= 1'b1;
               end else if (drsp.done) begin
                  ga_ff   <= gb_ff;
                  gb_ff   <= drsp.remainder;
                  wait_ff <= 1'b0;
               end
            end
            S_DIVN: begin
               if (!wait_ff) wait_ff <= 1'b1;
               else if (drsp.done) begin
                  qn_ff    <= drsp.quotient;
                  wait_ff  <= 1'b0;
                  state_ff <= S_DIVD;
               end
            end
            S_DIVD: begin
               if (!wait_ff) wait_ff <= 1'b1;
               else if (drsp.done) begin
                  dmag_ff  <= drsp.quotient;
                  wait_ff  <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // store only when both reduced values fit
               if (qn_ff > LIMIT || dmag_ff > LIMIT) begin
                  status_ff <= ST_OVERFLOW;
               end else begin
                  num_ff <= (neg_ff && qn_ff != 64'd0) ? (32'd0 - qn_ff[31:0])
                                                       : qn_ff[31:0];
                  den_ff <= dmag_ff[31:0];
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.result_numerator   = num_ff;
   assign rsp.result_denominator = den_ff[30:0];
   assign rsp.status             = status_ff;

   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> den_ff != 32'd0) else $error("zero held denominator");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(num_ff))
      else $error("response dropped");

endmodule

// File: hw/rtl/ra_divider.sv
// ra_divider: 64-bit restoring divider, one quotient bit per cycle
// depends on ra_pkg

module ra_divider
   import ra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[63:0], quo_ff[63]};
      trial   = shifted - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[63:0];

   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("divider did not start");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff[63:0] < dsr_ff || dsr_ff == 64'd0)
      else $error("remainder not below divisor");

endmodule
